// File: design/tws_pkg.sv
// Shared constants, types and the coordinate wrap function of the texture wrap sampler.
`default_nettype none

package tws_pkg;

    localparam int MAX_DIM    = 64;
    localparam int FRAC_BITS  = 16;

    localparam int COORD_W    = 32;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int TEXEL_IDX_W = 12;

    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int SIZE_W     = $clog2(MAX_DIM) + 1;
    localparam int WRAP_W     = FRAC_BITS + 1;
    localparam int PROD_W     = WRAP_W + SIZE_W;

    localparam logic [WRAP_W-1:0] WRAP_ONE = WRAP_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        WRAP_CLAMP  = 2'd0,
        WRAP_MIRROR = 2'd1,
        WRAP_TILE   = 2'd2
    } t_wrap_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 2'd0,
        CFG_TEX_HEIGHT = 2'd1,
        CFG_WRAP_MODE  = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // Maps a signed fixed point coordinate into the range zero to one inclusive.
    function automatic logic [WRAP_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input t_wrap_mode m);
        logic [COORD_W-1:0]   a;
        logic [FRAC_BITS-1:0] f;
        logic [WRAP_W-1:0]    res;
        a   = '0;
        f   = '0;
        res = '0;
        case (m)
            WRAP_MIRROR: begin
                if (c == {1'b1, {(COORD_W-1){1'b0}}}) begin
                    a = {1'b0, {(COORD_W-1){1'b1}}};
                end else if (c[COORD_W-1]) begin
                    a = ~c + COORD_W'(1);
                end else begin
                    a = c;
                end
                f = a[FRAC_BITS-1:0];
                if (a[FRAC_BITS]) begin
                    res = WRAP_ONE - {1'b0, f};
                end else begin
                    res = {1'b0, f};
                end
            end
            WRAP_TILE: begin
                res = {1'b0, c[FRAC_BITS-1:0]};
            end
            default: begin
                if (c[COORD_W-1]) begin
                    res = '0;
                end else if (c[COORD_W-2:0] > (COORD_W-1)'(WRAP_ONE)) begin
                    res = WRAP_ONE;
                end else begin
                    res = c[WRAP_W-1:0];
                end
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/texture_wrap_sampler_top.sv
// Top level of the one-bit texture sampler with clamp, mirror and tile addressing.
//
//   Channel   Direction  Handshake                      Payload
//   -------   ---------  -----------------------------  -----------------------------------
//   command   in         start high while busy low      i_op, i_coord_u, i_coord_v,
//                                                       i_texel_index, i_texel_value
//   result    out        o_strobe, one cycle, no stall  o_texel_on, o_texel_x, o_texel_y
//   config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// An item is taken in every cycle: busy is never raised, since nothing in the
// pipeline can hold up. A sample item passes three register stages before
// its result appears: wrap, scale and limit, then the registered read of
// the texel store. A write item gives no result and updates the store at
// the same stage at which samples read it, so items act on the store
// strictly in the order they were taken.
// Reset clears the stage valid bits and presets the configuration registers; the
// texel store is not cleared, and a texel must be written before it is read.
// The receiver cannot stall, so results simply leave on their strobe.
`default_nettype none

module texture_wrap_sampler_top
    import tws_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_op,
    input  wire logic [COORD_W-1:0]     i_coord_u,
    input  wire logic [COORD_W-1:0]     i_coord_v,
    input  wire logic [TEXEL_IDX_W-1:0] i_texel_index,
    input  wire logic                   i_texel_value,

    output logic                        o_strobe,
    output logic                        o_texel_on,
    output logic [IDX_W-1:0]            o_texel_x,
    output logic [IDX_W-1:0]            o_texel_y,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers. The sizes are held as effective sizes, so that
    // zero is already turned into one and anything too large into the maximum.
    logic [SIZE_W-1:0] r_tex_width;
    logic [SIZE_W-1:0] r_tex_height;
    t_wrap_mode        r_wrap_mode;
    logic [SIZE_W-1:0] n_cfg_size;

    // Stage one: wrapped coordinates.
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [WRAP_W-1:0] r_s1_u;
    logic [WRAP_W-1:0] r_s1_v;
    logic [TEXEL_IDX_W-1:0] r_s1_index;
    logic              r_s1_value;

    // Stage two: scaled and limited texel column and row.
    logic              r_s2_valid;
    t_op               r_s2_op;
    logic [IDX_W-1:0]  r_s2_x;
    logic [IDX_W-1:0]  r_s2_y;
    logic [TEXEL_IDX_W-1:0] r_s2_index;
    logic              r_s2_value;

    // Stage three: store read data comes out of the RAM register.
    logic              r_s3_valid;
    logic [IDX_W-1:0]  r_s3_x;
    logic [IDX_W-1:0]  r_s3_y;

    logic              accept;
    logic [PROD_W-1:0] n_prod_u;
    logic [PROD_W-1:0] n_prod_v;
    logic [PROD_W-FRAC_BITS-1:0] n_pix_u;
    logic [PROD_W-FRAC_BITS-1:0] n_pix_v;
    logic [PROD_W-FRAC_BITS-1:0] n_lim_u;
    logic [PROD_W-FRAC_BITS-1:0] n_lim_v;
    logic [IDX_W+SIZE_W-1:0]     n_row_base;
    logic [IDX_W+SIZE_W-1:0]     n_addr_full;
    logic              ram_we;
    logic              ram_rdata;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Effective size of a size write.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cfg_size = SIZE_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_DIM)) begin
            n_cfg_size = SIZE_W'(MAX_DIM);
        end else begin
            n_cfg_size = SIZE_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= SIZE_W'(MAX_DIM);
            r_tex_height <= SIZE_W'(MAX_DIM);
            r_wrap_mode  <= WRAP_CLAMP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_TEX_WIDTH: begin
                    r_tex_width <= n_cfg_size;
                end
                CFG_TEX_HEIGHT: begin
                    r_tex_height <= n_cfg_size;
                end
                CFG_WRAP_MODE: begin
                    // The unused mode code leaves the previous mode in place.
                    case (t_wrap_mode'(i_cfg_data[1:0]))
                        WRAP_CLAMP, WRAP_MIRROR, WRAP_TILE: begin
                            r_wrap_mode <= t_wrap_mode'(i_cfg_data[1:0]);
                        end
                        default: begin
                            r_wrap_mode <= r_wrap_mode;
                        end
                    endcase
                end
                default: begin
                    r_wrap_mode <= r_wrap_mode;
                end
            endcase
        end
    end

    // Stage one: apply the wrap mode to both coordinates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_op    <= t_op'(i_op);
        r_s1_u     <= wrap_coord(i_coord_u, r_wrap_mode);
        r_s1_v     <= wrap_coord(i_coord_v, r_wrap_mode);
        r_s1_index <= i_texel_index;
        r_s1_value <= i_texel_value;
    end

    // Stage two: scale by the size, drop the fraction and keep below the size.
    assign n_prod_u = PROD_W'(r_s1_u) * PROD_W'(r_tex_width);
    assign n_prod_v = PROD_W'(r_s1_v) * PROD_W'(r_tex_height);
    assign n_pix_u  = n_prod_u[PROD_W-1:FRAC_BITS];
    assign n_pix_v  = n_prod_v[PROD_W-1:FRAC_BITS];

    always_comb begin
        if (n_pix_u > (PROD_W-FRAC_BITS)'(r_tex_width - SIZE_W'(1))) begin
            n_lim_u = (PROD_W-FRAC_BITS)'(r_tex_width - SIZE_W'(1));
        end else begin
            n_lim_u = n_pix_u;
        end
        if (n_pix_v > (PROD_W-FRAC_BITS)'(r_tex_height - SIZE_W'(1))) begin
            n_lim_v = (PROD_W-FRAC_BITS)'(r_tex_height - SIZE_W'(1));
        end else begin
            n_lim_v = n_pix_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_op    <= r_s1_op;
        r_s2_x     <= n_lim_u[IDX_W-1:0];
        r_s2_y     <= n_lim_v[IDX_W-1:0];
        r_s2_index <= r_s1_index;
        r_s2_value <= r_s1_value;
    end

    // Stage three: row-major address, store write and store read.
    assign n_row_base  = (IDX_W+SIZE_W)'(r_s2_y) * (IDX_W+SIZE_W)'(r_tex_width);
    assign n_addr_full = n_row_base + (IDX_W+SIZE_W)'(r_s2_x);

    // Writes beyond the store are dropped.
    assign ram_we = r_s2_valid && (r_s2_op == OP_WRITE) &&
                    (32'(r_s2_index) < 32'(DEPTH));

    tws_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_texel_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_index[ADDR_W-1:0]),
        .i_wdata (r_s2_value),
        .i_raddr (n_addr_full[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid && (r_s2_op == OP_SAMPLE);
        end
        r_s3_x <= r_s2_x;
        r_s3_y <= r_s2_y;
    end

    assign o_strobe   = r_s3_valid;
    assign o_texel_on = ram_rdata;
    assign o_texel_x  = r_s3_x;
    assign o_texel_y  = r_s3_y;

    // A result strobe is always caused by a sample item that has passed through stages one, two and three.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept && (i_op == OP_SAMPLE), 3))
        else $error("result strobe without a matching sample item");

    // Wrapped coordinates never exceed one.
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_u <= WRAP_ONE) && (r_s1_v <= WRAP_ONE))
        else $error("wrapped coordinate above one");

    // Effective sizes stay between one and the maximum dimension.
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tex_width != '0) && (32'(r_tex_width) <= 32'(MAX_DIM)) &&
        (r_tex_height != '0) && (32'(r_tex_height) <= 32'(MAX_DIM)))
        else $error("effective texture size out of range");

endmodule

`default_nettype wire

// File: design/tws_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
